@@ hdl/lpl_pkg.sv @@
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants of the lookahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

  localparam int MAX_LOOKAHEAD = 64;
  localparam int MAX_CHANNELS  = 4;
  localparam int LA_W          = $clog2(MAX_LOOKAHEAD);
  localparam int CH_W          = $clog2(MAX_CHANNELS);

  localparam logic [16:0] UNITY_GAIN = 17'h10000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENABLED       = 3'd0;
  localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd1;
  localparam logic [2:0] CFG_CEILING       = 3'd2;
  localparam logic [2:0] CFG_RELEASE_COEF  = 3'd3;
  localparam logic [2:0] CFG_LOOKAHEAD     = 3'd4;

  typedef struct packed {
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
    logic               block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_0;
    logic signed [15:0] out_1;
    logic signed [15:0] out_2;
    logic signed [15:0] out_3;
    logic [16:0]        current_gain;
    logic               result_last;
  } out_item_t;

  // One lookahead slot: the frame peak and the delayed samples.
  typedef struct packed {
    logic [14:0]                   peak;
    logic [MAX_CHANNELS-1:0][15:0] smp;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [14:0] dividend;
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

@@ hdl/lookahead_peak_limiter_top.sv @@
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_top
// Lookahead peak limiter for up to four Q1.15 channels per frame item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | lpl_pkg::in_item_t
//  out_    | output    | out_valid / out_ready| lpl_pkg::out_item_t
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// An enabled item, once accepted, passes through these states in order: a scan
// in which the ring of 64 cells rotates once past the head to update the slot and
// find the window peak, the divide state (which waits on the divider only when the
// window peak is above the ceiling), a gain state, a release state that an attack
// skips, the per-channel scaling multiplier and the load of the output register.
// A disabled item goes from idle straight to the load of the output register.
// Items are taken one at a time; a new item is accepted while the previous
// result still waits on out_ready. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lpl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_GAIN  = 7'b0001000,
    S_REL   = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic        en_r;
  logic [2:0]  chc_r;
  logic [14:0] ceil_r;
  logic [15:0] coef_r;
  logic [6:0]  lal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      chc_r  <= 3'd2;
      ceil_r <= 15'd32440;
      coef_r <= 16'd27;
      lal_r  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        lpl_pkg::CFG_ENABLED:       en_r   <= cfg_data[0];
        lpl_pkg::CFG_CHANNEL_COUNT: chc_r  <= cfg_data[2:0];
        lpl_pkg::CFG_CEILING:       ceil_r <= cfg_data[14:0];
        lpl_pkg::CFG_RELEASE_COEF:  coef_r <= cfg_data;
        lpl_pkg::CFG_LOOKAHEAD:     lal_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [2:0] ch_eff;
  logic [6:0] len_eff;
  logic [lpl_pkg::LA_W-1:0] wp_r, wp_nxt, pos_eff;

  assign ch_eff  = (chc_r == 3'd0) ? 3'd1 :
                   (chc_r > 3'(lpl_pkg::MAX_CHANNELS)) ? 3'(lpl_pkg::MAX_CHANNELS) : chc_r;
  assign len_eff = (lal_r == 7'd0) ? 7'd1 :
                   (lal_r > 7'(lpl_pkg::MAX_LOOKAHEAD)) ? 7'(lpl_pkg::MAX_LOOKAHEAD) : lal_r;
  assign pos_eff = ({1'b0, wp_r} >= len_eff) ? '0 : wp_r;

  // Held input item and its samples as lanes.
  lpl_pkg::in_item_t in_r;
  logic signed [15:0] smp [lpl_pkg::MAX_CHANNELS];
  assign smp[0] = in_r.sample_0;
  assign smp[1] = in_r.sample_1;
  assign smp[2] = in_r.sample_2;
  assign smp[3] = in_r.sample_3;

  logic signed [15:0] in_smp [lpl_pkg::MAX_CHANNELS];
  assign in_smp[0] = in_data.sample_0;
  assign in_smp[1] = in_data.sample_1;
  assign in_smp[2] = in_data.sample_2;
  assign in_smp[3] = in_data.sample_3;

  // Peak magnitude of the held frame; -32768 saturates to 32767.
  logic [14:0] new_peak;
  always_comb begin
    logic [15:0] m;
    new_peak = '0;
    for (int c = 0; c < lpl_pkg::MAX_CHANNELS; c++) begin
      m = smp[c][15] ? 16'(-smp[c]) : smp[c];
      if (m[15]) m = 16'h7FFF;
      if ((3'(c) < ch_eff) && (m[14:0] > new_peak)) new_peak = m[14:0];
    end
  end

  // Rotating ring: after k shifts the head cell holds slot k.
  lpl_pkg::entry_t ring_q [lpl_pkg::MAX_LOOKAHEAD];
  lpl_pkg::entry_t head_mod;
  logic            shift_en;
  logic [lpl_pkg::LA_W-1:0] scan_k_r;
  logic            hit;

  assign shift_en = (state_r == S_SCAN);
  assign hit      = (scan_k_r == pos_eff);

  always_comb begin
    head_mod = ring_q[0];
    if (hit) begin
      head_mod.peak = new_peak;
      for (int c = 0; c < lpl_pkg::MAX_CHANNELS; c++) begin
        if (3'(c) < ch_eff) head_mod.smp[c] = smp[c];
      end
    end
  end

  for (genvar i = 0; i < lpl_pkg::MAX_LOOKAHEAD; i++) begin : g_ring
    lpl_pkg::entry_t d_i;
    if (i == lpl_pkg::MAX_LOOKAHEAD - 1) begin : g_tail
      assign d_i = head_mod;
    end else begin : g_mid
      assign d_i = ring_q[i+1];
    end
    lpl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (d_i),
      .q_out    (ring_q[i])
    );
  end

  logic [14:0] win_r, win_nxt, scan_val;
  logic        need_div_r;
  logic signed [15:0] dly_r [lpl_pkg::MAX_CHANNELS];

  assign scan_val = hit ? new_peak : ring_q[0].peak;
  assign win_nxt  = (({1'b0, scan_k_r} < len_eff) && (scan_val > win_r)) ? scan_val : win_r;

  // Divider.
  lpl_pkg::div_req_t div_req;
  lpl_pkg::div_rsp_t div_rsp;
  logic              div_start_r;

  assign div_req.start    = div_start_r;
  assign div_req.dividend = ceil_r;
  assign div_req.divisor  = win_r;

  lpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  localparam int CH_IDX_W = lpl_pkg::CH_W;
  logic [16:0] needed_r;
  logic [16:0] gain_r;
  logic [32:0] prod_r;
  logic [33:0] rel_sum;
  logic [CH_IDX_W-1:0] cc_r;

  assign rel_sum = {1'b0, prod_r} + 34'd65535;

  // Scaling of one lane: truncate toward zero, clamp to the ceiling.
  logic signed [33:0] sc_p;
  logic signed [33:0] sc_b;
  logic signed [17:0] sc_q;
  logic signed [15:0] sc_o;
  always_comb begin
    sc_p = dly_r[cc_r] * $signed({1'b0, gain_r});
    sc_b = sc_p[33] ? (sc_p + 34'sd65535) : sc_p;
    sc_q = 18'(sc_b >>> 16);
    if (sc_q > $signed({3'b0, ceil_r})) sc_o = $signed({1'b0, ceil_r});
    else if (sc_q < -$signed({3'b0, ceil_r})) sc_o = 16'(-$signed({3'b0, ceil_r}));
    else sc_o = sc_q[15:0];
  end

  logic signed [15:0] res_smp [lpl_pkg::MAX_CHANNELS];
  logic [16:0]        res_gain_r;
  logic               out_valid_r;
  lpl_pkg::out_item_t out_r;
  logic               in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = en_r ? S_SCAN : S_DONE;
      S_SCAN: begin
        if (scan_k_r == lpl_pkg::LA_W'(lpl_pkg::MAX_LOOKAHEAD - 1)) begin
          state_nxt = S_DIV;
          wp_nxt = ({1'b0, pos_eff} + 7'd1 >= len_eff) ? '0 : pos_eff + 1'b1;
        end
      end
      S_DIV:   if (!need_div_r || div_rsp.done) state_nxt = S_GAIN;
      S_GAIN:  state_nxt = (needed_r < gain_r) ? S_SCALE : S_REL;
      S_REL:   state_nxt = S_SCALE;
      S_SCALE: if (cc_r == CH_IDX_W'(lpl_pkg::MAX_CHANNELS - 1)) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      gain_r      <= lpl_pkg::UNITY_GAIN;
      scan_k_r    <= '0;
      cc_r        <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      div_start_r <= 1'b0;
      if (state_r == S_SCAN) begin
        scan_k_r <= scan_k_r + 1'b1;
        if (scan_k_r == lpl_pkg::LA_W'(lpl_pkg::MAX_LOOKAHEAD - 1)) begin
          div_start_r <= (win_nxt > ceil_r);
        end
      end
      if (state_r == S_GAIN && needed_r < gain_r) gain_r <= needed_r;
      if (state_r == S_REL) gain_r <= gain_r + rel_sum[32:16];
      if (state_r == S_SCALE) cc_r <= cc_r + 1'b1;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r    <= in_data;
      win_r   <= '0;
      res_gain_r <= lpl_pkg::UNITY_GAIN;
      for (int c = 0; c < lpl_pkg::MAX_CHANNELS; c++) begin
        res_smp[c] <= (3'(c) < ch_eff) ? in_smp[c] : 16'sd0;
      end
    end
    if (state_r == S_SCAN) begin
      win_r <= win_nxt;
      if (hit) begin
        for (int c = 0; c < lpl_pkg::MAX_CHANNELS; c++) dly_r[c] <= ring_q[0].smp[c];
      end
      need_div_r <= (win_nxt > ceil_r);
    end
    if (state_r == S_DIV) needed_r <= need_div_r ? {1'b0, div_rsp.quot} : lpl_pkg::UNITY_GAIN;
    if (state_r == S_GAIN) prod_r <= {16'd0, needed_r - gain_r} * {17'd0, coef_r};
    if (state_r == S_SCALE) begin
      res_smp[cc_r] <= (3'(cc_r) < ch_eff) ? sc_o : 16'sd0;
      res_gain_r    <= gain_r;
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r.out_0        <= res_smp[0];
      out_r.out_1        <= res_smp[1];
      out_r.out_2        <= res_smp[2];
      out_r.out_3        <= res_smp[3];
      out_r.current_gain <= res_gain_r;
      out_r.result_last  <= in_r.block_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= lpl_pkg::UNITY_GAIN)
    else $error("gain above unity");

  a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (scan_k_r == '0))
    else $error("scan counter not parked outside scan");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN || state_r == S_DONE))
    else $error("accepted item did not start");

endmodule

@@ hdl/lpl_cell.sv @@
// ----------------------------------------------------------------------------
// lpl_cell
// One slot of the rotating lookahead ring; takes its neighbor's slot on shift.
// ----------------------------------------------------------------------------
module lpl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  lpl_pkg::entry_t d_in,
  output lpl_pkg::entry_t q_out
);

  lpl_pkg::entry_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (shift_en) begin
      slot_r <= d_in;
    end
  end

  assign q_out = slot_r;

endmodule

@@ hdl/lpl_div.sv @@
// ----------------------------------------------------------------------------
// lpl_div
// Restoring divider: (dividend << 16) / divisor, one quotient bit per cycle.
// The dividend must be below the divisor, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module lpl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lpl_pkg::div_req_t req,
  output lpl_pkg::div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quot_r, quot_nxt;
  logic [14:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [15:0] sh;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    sh       = {rem_r[14:0], 1'b0};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, req.dividend};
      quot_nxt = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt  = sh - {1'b0, dvs_r};
        quot_nxt = {quot_r[14:0], 1'b1};
      end else begin
        rem_nxt  = sh;
        quot_nxt = {quot_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

@@ verif/tb_lookahead_peak_limiter_top.sv @@
// ----------------------------------------------------------------------------
// tb_lookahead_peak_limiter_top
// Drives frames through the limiter under several register settings and
// checks every output frame against a cycle-free model of the limiter.
// ----------------------------------------------------------------------------
module tb_lookahead_peak_limiter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  lpl_pkg::in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  lpl_pkg::out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = lpl_pkg::CFG_ENABLED;
  logic [15:0] cfg_data = '0;

  lookahead_peak_limiter_top dut (.*);

  always #5 clk = ~clk;

  // Limiter state mirrored on the testbench side.
  logic        lim_en;
  logic [2:0]  lim_chans;
  logic [14:0] lim_ceil;
  logic [15:0] lim_rel;
  logic [6:0]  lim_len;
  logic signed [15:0] frame_ring [lpl_pkg::MAX_LOOKAHEAD][lpl_pkg::MAX_CHANNELS];
  logic [14:0] peak_ring [lpl_pkg::MAX_LOOKAHEAD];
  int unsigned ring_pos;
  logic [16:0] gain_now;

  lpl_pkg::out_item_t expected_frames[$];
  int  errors = 0;
  bit  calm = 1'b0;
  bit  hold_out = 1'b0;
  int  idle_cycles = 0;

  task automatic model_reset();
    lim_en = 1'b1; lim_chans = 3'd2; lim_ceil = 15'd32440;
    lim_rel = 16'd27; lim_len = 7'd64;
    for (int i = 0; i < lpl_pkg::MAX_LOOKAHEAD; i++) begin
      peak_ring[i] = '0;
      for (int c = 0; c < lpl_pkg::MAX_CHANNELS; c++) frame_ring[i][c] = '0;
    end
    ring_pos = 0;
    gain_now = lpl_pkg::UNITY_GAIN;
  endtask

  function automatic lpl_pkg::out_item_t limit_frame(lpl_pkg::in_item_t f);
    lpl_pkg::out_item_t r;
    int unsigned nch, len, pk, win, need;
    logic signed [15:0] s [lpl_pkg::MAX_CHANNELS];
    longint p, q;
    nch = (lim_chans < 1) ? 1 :
          (lim_chans > lpl_pkg::MAX_CHANNELS) ? lpl_pkg::MAX_CHANNELS : lim_chans;
    len = (lim_len < 1) ? 1 :
          (lim_len > lpl_pkg::MAX_LOOKAHEAD) ? lpl_pkg::MAX_LOOKAHEAD : lim_len;
    s[0] = f.sample_0; s[1] = f.sample_1; s[2] = f.sample_2; s[3] = f.sample_3;
    r = '0;
    r.result_last = f.block_last;
    if (!lim_en) begin
      if (nch > 0) r.out_0 = s[0];
      if (nch > 1) r.out_1 = s[1];
      if (nch > 2) r.out_2 = s[2];
      if (nch > 3) r.out_3 = s[3];
      r.current_gain = lpl_pkg::UNITY_GAIN;
      return r;
    end
    if (ring_pos >= len) ring_pos = 0;
    pk = 0;
    for (int c = 0; c < nch; c++) begin
      int m;
      m = (s[c] < 0) ? -int'(s[c]) : int'(s[c]);
      if (m > 32767) m = 32767;
      if (m > pk) pk = m;
    end
    peak_ring[ring_pos] = 15'(pk);
    win = 0;
    for (int i = 0; i < len; i++) if (peak_ring[i] > win) win = peak_ring[i];
    need = (win > lim_ceil) ? int'((longint'(lim_ceil) << 16) / win) : lpl_pkg::UNITY_GAIN;
    if (need < gain_now) gain_now = 17'(need);
    else gain_now += 17'(((longint'(need - gain_now) * lim_rel) + 65535) >> 16);
    for (int c = 0; c < nch; c++) begin
      p = longint'(frame_ring[ring_pos][c]) * longint'(gain_now);
      q = (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
      if (q > longint'(lim_ceil)) q = longint'(lim_ceil);
      if (q < -longint'(lim_ceil)) q = -longint'(lim_ceil);
      frame_ring[ring_pos][c] = s[c];
      case (c)
        0: r.out_0 = 16'(q);
        1: r.out_1 = 16'(q);
        2: r.out_2 = 16'(q);
        default: r.out_3 = 16'(q);
      endcase
    end
    r.current_gain = gain_now;
    ring_pos++;
    if (ring_pos >= len) ring_pos = 0;
    return r;
  endfunction

  // Registers are only written while the limiter is idle.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      lpl_pkg::CFG_ENABLED:       lim_en = val[0];
      lpl_pkg::CFG_CHANNEL_COUNT: lim_chans = val[2:0];
      lpl_pkg::CFG_CEILING:       lim_ceil = val[14:0];
      lpl_pkg::CFG_RELEASE_COEF:  lim_rel = val;
      lpl_pkg::CFG_LOOKAHEAD:     lim_len = val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic send_frame(lpl_pkg::in_item_t f);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 11)) @(negedge clk);
    in_valid = 1'b1; in_data = f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_frames.push_back(limit_frame(f));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 200)) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lpl_pkg::in_item_t rand_frame();
    lpl_pkg::in_item_t f;
    f.sample_0 = rand_sample(); f.sample_1 = rand_sample();
    f.sample_2 = rand_sample(); f.sample_3 = rand_sample();
    f.block_last = 1'($urandom);
    return f;
  endfunction

  // Receiver: random stalls, plus one long hold-off requested by the stimulus.
  always @(negedge clk) begin
    if (hold_out) out_ready <= 1'b0;
    else if (!calm && $urandom_range(0, 5) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      lpl_pkg::out_item_t e;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame %h", $time, out_data);
        errors++;
      end else begin
        e = expected_frames.pop_front();
        if (out_data.out_0 !== e.out_0 || out_data.out_1 !== e.out_1 ||
            out_data.out_2 !== e.out_2 || out_data.out_3 !== e.out_3 ||
            out_data.current_gain !== e.current_gain ||
            out_data.result_last !== e.result_last) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    lpl_pkg::in_item_t frame;
    bit         known;
    logic [16:0] gain;
  } vector_t;

  initial begin
    vector_t vectors[$];
    model_reset();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at reset settings: silence gives unity gain.
    vectors.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b1, lpl_pkg::UNITY_GAIN});
    vectors.push_back('{'{16'sh7fff, 16'sh8000, 16'sd5, 16'sd7, 1'b1}, 1'b0, '0});
    vectors.push_back('{'{16'sh8000, 16'sh7fff, -16'sd1, 16'sd1, 1'b0}, 1'b0, '0});
    vectors.push_back('{'{16'sd32440, -16'sd32440, 16'sd0, 16'sd0, 1'b1}, 1'b0, '0});
    vectors.push_back('{'{16'sd100, -16'sd100, 16'sh7fff, 16'sh8000, 1'b0}, 1'b0, '0});
    foreach (vectors[i]) begin
      send_frame(vectors[i].frame);
      if (vectors[i].known && expected_frames[$].current_gain !== vectors[i].gain) begin
        $display("%0t: table gain expected %h actual %h", $time, vectors[i].gain,
                 expected_frames[$].current_gain);
        errors++;
      end
    end
    drain();

    // Short window, all four channels, zero ceiling.
    write_reg(lpl_pkg::CFG_LOOKAHEAD, 16'd1);
    write_reg(lpl_pkg::CFG_CHANNEL_COUNT, 16'd4);
    write_reg(lpl_pkg::CFG_CEILING, 16'd0);
    for (int i = 0; i < 6; i++) send_frame(rand_frame());
    drain();
    write_reg(lpl_pkg::CFG_CEILING, 16'd1);
    write_reg(lpl_pkg::CFG_RELEASE_COEF, 16'hffff);
    for (int i = 0; i < 6; i++) send_frame(rand_frame());
    drain();
    // Disabled pass-through, then out-of-range codes for count and length.
    write_reg(lpl_pkg::CFG_ENABLED, 16'd0);
    for (int i = 0; i < 4; i++) send_frame(rand_frame());
    drain();
    write_reg(lpl_pkg::CFG_ENABLED, 16'd1);
    write_reg(lpl_pkg::CFG_CHANNEL_COUNT, 16'd0);
    write_reg(lpl_pkg::CFG_LOOKAHEAD, 16'd0);
    for (int i = 0; i < 4; i++) send_frame(rand_frame());
    drain();
    write_reg(lpl_pkg::CFG_CHANNEL_COUNT, 16'd7);
    write_reg(lpl_pkg::CFG_LOOKAHEAD, 16'd127);
    write_reg(lpl_pkg::CFG_CEILING, 16'd32767);
    write_reg(lpl_pkg::CFG_RELEASE_COEF, 16'd0);
    for (int i = 0; i < 4; i++) send_frame(rand_frame());
    drain();

    // Long receiver hold-off so the limiter fills and stalls its input.
    hold_out = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_frame(rand_frame());
    join
    drain();

    // Random phases, each with fresh settings; the last runs without idling.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) calm = 1'b1;
      write_reg(lpl_pkg::CFG_ENABLED, ($urandom_range(0, 7) == 0) ? 16'd0 : 16'd1);
      write_reg(lpl_pkg::CFG_CHANNEL_COUNT, 16'($urandom_range(0, 7)));
      write_reg(lpl_pkg::CFG_CEILING,
                16'($urandom_range(0, 3) == 0 ? $urandom_range(1, 32767)
                                              : $urandom_range(8000, 32767)));
      write_reg(lpl_pkg::CFG_RELEASE_COEF, 16'($urandom));
      write_reg(lpl_pkg::CFG_LOOKAHEAD,
                16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                              : $urandom_range(1, 16)));
      for (int i = 0; i < 150; i++) send_frame(rand_frame());
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/lpl_pkg.sv
hdl/lpl_cell.sv
hdl/lpl_div.sv
hdl/lookahead_peak_limiter_top.sv
verif/tb_lookahead_peak_limiter_top.sv
